@@ rtl/bcd_calendar_epoch_converter_assert.svh @@
// Assertion macros for the BCD calendar and epoch converter.
`ifndef BCD_CALENDAR_EPOCH_CONVERTER_ASSERT_SVH
`define BCD_CALENDAR_EPOCH_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bcec_pkg.sv @@
// Types, constants and helper functions of the BCD calendar and epoch converter.
package bcec_pkg;

    localparam int ST_N = 18;

    // Conversion direction carried in tuser.
    localparam logic FN_TO_EPOCH = 1'b0;
    localparam logic FN_TO_DATE  = 1'b1;

    localparam logic [31:0] MJD_OFS    = 32'd678912;
    localparam logic [31:0] MJD_EPOCH  = 32'd40587;
    localparam logic [31:0] SEC_DAY    = 32'd86400;
    localparam logic [31:0] JDN_EPOCH4 = 32'd719468;

    // Reciprocals for constant division: ceil(2^S/d) is exact over the stated range; M_DAY is floor(2^32/86400).
    localparam longint unsigned M_Y100    = ((64'd1 << 23) + 64'd99) / 64'd100;
    localparam longint unsigned M_Y400    = ((64'd1 << 25) + 64'd399) / 64'd400;
    localparam longint unsigned M_M100    = ((64'd1 << 26) + 64'd99) / 64'd100;
    localparam longint unsigned M_DAY     = (64'd1 << 32) / 64'd86400;
    localparam longint unsigned M_W7      = ((64'd1 << 19) + 64'd6) / 64'd7;
    localparam longint unsigned M_H3600   = ((64'd1 << 29) + 64'd3599) / 64'd3600;
    localparam longint unsigned M_M60     = ((64'd1 << 23) + 64'd59) / 64'd60;
    localparam longint unsigned M_M60S    = ((64'd1 << 17) + 64'd59) / 64'd60;
    localparam longint unsigned M_C146097 = ((64'd1 << 40) + 64'd146096) / 64'd146097;
    localparam longint unsigned M_Y1461   = ((64'd1 << 33) + 64'd1460) / 64'd1461;
    localparam longint unsigned M_L153    = ((64'd1 << 19) + 64'd152) / 64'd153;
    localparam longint unsigned M_D5      = ((64'd1 << 11) + 64'd4) / 64'd5;
    localparam longint unsigned M_Y100D   = ((64'd1 << 21) + 64'd99) / 64'd100;
    localparam longint unsigned M_B10     = ((64'd1 << 11) + 64'd9) / 64'd10;
    localparam longint unsigned M_H24     = ((64'd1 << 13) + 64'd23) / 64'd24;

    typedef struct packed {
        logic        func;
        logic [31:0] epoch;
        logic [31:0] mjd;
        logic [2:0]  wd;
        logic [31:0] date;
        logic [23:0] tim;
        logic [15:0] yr;
        logic [7:0]  mon;
        logic [7:0]  day;
        logic [4:0]  hr;
        logic [5:0]  mi;
        logic [5:0]  se;
        logic [16:0] tod;
        logic [9:0]  c100;
        logic [7:0]  c400;
        logic [18:0] mp;
        logic [31:0] ysum;
        logic [12:0] mt;
        logic [15:0] q;
        logic [17:0] r;
        logic [15:0] wx;
        logic [12:0] wq;
        logic [10:0] mq;
        logic [4:0]  mh;
        logic [21:0] jdn4;
        logic [4:0]  cq;
        logic [21:0] base;
        logic [11:0] bq;
        logic [10:0] bm;
        logic [10:0] leap;
        logic [3:0]  lq;
        logic [4:0]  dmon;
        logic [7:0]  lr;
        logic [4:0]  dday;
        logic [11:0] dyr;
        logic [6:0]  yh;
        logic [6:0]  yl;
    } t_item;

    // BCD byte to value, non-decimal nibbles taken arithmetically.
    function automatic logic [7:0] bcd_val(input logic [7:0] b);
        return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
    endfunction

    function automatic logic [5:0] mod60(input logic [7:0] v);
        logic [7:0] t;
        if (v >= 8'd120) begin
            t = v - 8'd120;
        end else if (v >= 8'd60) begin
            t = v - 8'd60;
        end else begin
            t = v;
        end
        return t[5:0];
    endfunction

    function automatic logic [4:0] mod24(input logic [7:0] v);
        logic [63:0] p;
        logic [7:0]  qq;
        logic [7:0]  t;
        p  = 64'(v) * M_H24;
        qq = 8'(p >> 13);
        t  = v - qq * 8'd24;
        return t[4:0];
    endfunction

    // Value below 100 to a BCD byte.
    function automatic logic [7:0] bcd2(input logic [6:0] d);
        logic [63:0] p;
        logic [6:0]  qq;
        logic [6:0]  rr;
        p  = 64'(d) * M_B10;
        qq = 7'(p >> 11);
        rr = d - qq * 7'd10;
        return {qq[3:0], rr[3:0]};
    endfunction

endpackage

@@ rtl/bcd_calendar_epoch_converter.sv @@
// BCD date/time to Unix epoch converter and back, as an 18-stage pipeline.
`include "bcd_calendar_epoch_converter_assert.svh"

// One transaction per clock cycle in each direction when the output side does not stall. Every
// stage holds its own valid bit, so an output stall fills empty stages first and halts input
// only when all 18 stages hold results. The stages carry the chain of constant-reciprocal
// multiplies that splits the epoch into days, time of day and the March-based calendar date.
// tuser carries func (0: date/time to epoch, 1: epoch to date/time).
module bcd_calendar_epoch_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [87:0]  i_s_axis_tdata,  // date_in[31:0], time_in[55:32], epoch_in[87:56]
    input  logic         i_s_axis_tuser,  // func
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // epoch_out[31:0], mjd_out[63:32], weekday[66:64], date_out[98:67], time_out[122:99]
    output logic [127:0] o_m_axis_tdata
);
    import bcec_pkg::*;

    t_item             r_st [1:ST_N];
    t_item             n_st [1:ST_N];
    logic [ST_N:1]     r_vld;
    logic [ST_N+1:1]   w_en;

    always_comb begin
        w_en[ST_N+1] = i_m_axis_tready;
        for (int k = ST_N; k >= 1; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[1];
    assign o_m_axis_tvalid = r_vld[ST_N];
    assign o_m_axis_tdata  = {5'b0, r_st[ST_N].tim, r_st[ST_N].date, r_st[ST_N].wd,
                              r_st[ST_N].mjd, r_st[ST_N].epoch};

    always_comb begin
        logic [7:0]  v_mon;
        logic [15:0] v_yr;
        logic [6:0]  v_k;
        t_item       s;

        // stage 1: decode BCD fields, fold month into March-based year
        s       = '0;
        s.func  = i_s_axis_tuser;
        s.epoch = i_s_axis_tdata[87:56];
        s.day   = bcd_val(i_s_axis_tdata[7:0]);
        v_mon   = bcd_val(i_s_axis_tdata[15:8]);
        v_yr    = 16'(bcd_val(i_s_axis_tdata[23:16]))
                + 16'(bcd_val(i_s_axis_tdata[31:24])) * 16'd100;
        if (v_mon < 8'd3) begin
            s.yr  = v_yr - 16'd1;
            s.mon = v_mon + 8'd12;
        end else begin
            s.yr  = v_yr;
            s.mon = v_mon;
        end
        s.se = mod60(bcd_val(i_s_axis_tdata[39:32]));
        s.mi = mod60(bcd_val(i_s_axis_tdata[47:40]));
        s.hr = mod24(bcd_val(i_s_axis_tdata[55:48]));
        n_st[1] = s;

        // stage 2: century terms, month term, time of day
        s      = r_st[1];
        s.c100 = 10'((64'(s.yr) * M_Y100) >> 23);
        s.c400 = 8'((64'(s.yr) * M_Y400) >> 25);
        s.mp   = 19'(s.mon - 8'd2) * 19'd3059;
        s.tod  = 17'(s.hr) * 17'd3600 + 17'(s.mi) * 17'd60 + 17'(s.se);
        n_st[2] = s;

        // stage 3: 36525*y/100 splits into 365*y + y/4
        s      = r_st[2];
        s.ysum = 32'(s.yr) * 32'd365 + 32'(s.yr[15:2]) + 32'(s.c400) - 32'(s.c100);
        s.mt   = 13'((64'(s.mp) * M_M100) >> 26);
        n_st[3] = s;

        // stage 4
        s     = r_st[3];
        s.mjd = s.ysum + 32'(s.mt) + 32'(s.day) - MJD_OFS;
        n_st[4] = s;

        // stage 5
        s = r_st[4];
        if (s.func == FN_TO_EPOCH) begin
            s.epoch = (s.mjd - MJD_EPOCH) * SEC_DAY + 32'(s.tod);
        end
        n_st[5] = s;

        // stage 6: day estimate, low by at most one
        s   = r_st[5];
        s.q = 16'((64'(s.epoch) * M_DAY) >> 32);
        n_st[6] = s;

        // stage 7
        s   = r_st[6];
        s.r = 18'(s.epoch - 32'(s.q) * SEC_DAY);
        n_st[7] = s;

        // stage 8: correct the day estimate
        s = r_st[7];
        if (s.r >= 18'(SEC_DAY)) begin
            s.q = s.q + 16'd1;
            s.r = s.r - 18'(SEC_DAY);
        end
        n_st[8] = s;

        // stage 9
        s = r_st[8];
        if (s.func == FN_TO_DATE) begin
            s.mjd = 32'(s.q) + MJD_EPOCH;
        end
        s.wx   = s.q + 16'd4;
        s.wq   = 13'((64'(s.wx) * M_W7) >> 19);
        s.hr   = 5'((64'(s.r) * M_H3600) >> 29);
        s.mq   = 11'((64'(s.r) * M_M60) >> 23);
        s.jdn4 = 22'((32'(s.q) + JDN_EPOCH4) << 2);
        s.cq   = 5'((64'(s.jdn4 + 22'd4) * M_C146097) >> 40);
        n_st[9] = s;

        // stage 10
        s      = r_st[9];
        s.wd   = 3'(s.wx - 16'(s.wq) * 16'd7);
        s.se   = 6'(s.r - 18'(s.mq) * 18'd60);
        s.mh   = 5'((64'(s.mq) * M_M60S) >> 17);
        v_k    = (7'(s.cq) + 7'd1) * 7'd3;
        s.base = s.jdn4 + 22'({v_k[6:2], 2'b00}) + 22'd3;
        n_st[10] = s;

        // stage 11
        s    = r_st[10];
        s.mi = 6'(s.mq - 11'(s.mh) * 11'd60);
        s.bq = 12'((64'(s.base) * M_Y1461) >> 33);
        n_st[11] = s;

        // stage 12
        s    = r_st[11];
        s.bm = 11'(s.base - 22'(s.bq) * 22'd1461);
        n_st[12] = s;

        // stage 13
        s      = r_st[12];
        s.leap = 11'(s.bm[10:2]) * 11'd5 + 11'd2;
        s.lq   = 4'((64'(s.leap) * M_L153) >> 19);
        n_st[13] = s;

        // stage 14
        s      = r_st[13];
        s.dmon = 5'(s.lq) + 5'd3;
        s.lr   = 8'(s.leap - 11'(s.lq) * 11'd153);
        n_st[14] = s;

        // stage 15: months past December roll into the next year
        s      = r_st[14];
        s.dday = 5'((64'(s.lr) * M_D5) >> 11) + 5'd1;
        if (s.dmon > 5'd12) begin
            s.dyr  = s.bq + 12'd1;
            s.dmon = s.dmon - 5'd12;
        end else begin
            s.dyr  = s.bq;
        end
        n_st[15] = s;

        // stage 16: year stays below 10000 for every 32-bit epoch
        s    = r_st[15];
        s.yh = 7'((64'(s.dyr) * M_Y100D) >> 21);
        n_st[16] = s;

        // stage 17
        s    = r_st[16];
        s.yl = 7'(s.dyr - 12'(s.yh) * 12'd100);
        n_st[17] = s;

        // stage 18: pack BCD results, zero for the date-to-epoch direction
        s = r_st[17];
        if (s.func == FN_TO_DATE) begin
            s.date = {bcd2(s.yh), bcd2(s.yl), bcd2(7'(s.dmon)), bcd2(7'(s.dday))};
            s.tim  = {bcd2(7'(s.hr)), bcd2(7'(s.mi)), bcd2(7'(s.se))};
        end else begin
            s.date = '0;
            s.tim  = '0;
        end
        n_st[18] = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= ST_N; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= ST_N; k++) begin
            if (w_en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    `BCEC_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, r_vld[8], r_st[8].r < 18'(SEC_DAY),
        "time of day out of range after day correction")
    `BCEC_ASSERT_NOW(a_wd_range, i_clk, i_rst_n, o_m_axis_tvalid,
        o_m_axis_tdata[66:64] != 3'd7, "weekday out of range")
    `BCEC_ASSERT_NOW(a_zero_fields, i_clk, i_rst_n,
        r_vld[ST_N] && (r_st[ST_N].func == FN_TO_EPOCH),
        r_st[ST_N].date == 32'd0 && r_st[ST_N].tim == 24'd0,
        "date or time nonzero for date-to-epoch result")
    `BCEC_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, (&r_vld) && !i_m_axis_tready,
        !o_s_axis_tready, "input taken while pipeline full and stalled")
    `BCEC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata),
        "stalled result dropped or changed")

endmodule

@@ test/tb.sv @@
// Testbench for the BCD calendar and epoch converter: predicts each result and checks it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcec_pkg::*;

    localparam int LATENCY     = 18;

    typedef struct packed {
        logic        func;
        logic [31:0] date;
        logic [23:0] tim;
        logic [31:0] epoch;
    } conv_req_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [31:0] mjd;
        logic [2:0]  wday;
        logic [31:0] date;
        logic [23:0] tim;
    } conv_res_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic [87:0]  i_s_axis_tdata = '0;
    logic         i_s_axis_tuser = 1'b0;
    logic         i_m_axis_tready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [127:0] o_m_axis_tdata;

    conv_req_t pending_reqs[$];
    conv_res_t expected_results[$];
    int        error_count = 0;
    bit        hold_off = 1'b0;
    bit        in_taken = 1'b0;

    bcd_calendar_epoch_converter dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] bcd_byte(input logic [31:0] b);
        return 32'(b[7:4]) * 10 + 32'(b[3:0]);
    endfunction

    function automatic logic [31:0] to_bcd(input logic [31:0] d);
        return ((d / 10) << 4) + (d % 10);
    endfunction

    function automatic logic [31:0] day_number(input logic [31:0] date);
        logic [31:0] dd, mm, yy;
        dd = bcd_byte(date);
        mm = bcd_byte(date >> 8);
        yy = (bcd_byte(date >> 16) + bcd_byte(date >> 24) * 100) & 32'hFFFF;
        if (mm < 3) begin
            yy = (yy - 1) & 32'hFFFF;
            mm = mm + 12;
        end
        return 32'd36525 * yy / 100 + yy / 400 - yy / 100
             + 32'd3059 * (mm - 2) / 100 + dd - 32'd678912;
    endfunction

    function automatic logic [31:0] calendar_date(input logic [31:0] mjd);
        logic [31:0] jdn, base, leap, yy, mm, dd;
        jdn  = mjd + 32'd678881;
        base = (jdn << 2) + ((((((jdn + 1) << 2) / 32'd146097 + 1) * 3) >> 2) << 2) + 3;
        leap = ((base % 1461) >> 2) * 5 + 2;
        yy   = base / 1461;
        mm   = leap / 153 + 3;
        dd   = (leap % 153) / 5 + 1;
        if (mm > 12) begin
            yy = yy + 1;
            mm = mm - 12;
        end
        yy = yy % 10000;
        return (to_bcd(yy / 100) << 24) | (to_bcd(yy % 100) << 16) | (to_bcd(mm) << 8)
             | to_bcd(dd);
    endfunction

    function automatic conv_res_t convert(input conv_req_t r);
        conv_res_t res;
        logic [31:0] secs;
        res = '0;
        if (r.func == FN_TO_EPOCH) begin
            res.mjd = day_number(r.date);
            secs = 3600 * (bcd_byte(32'(r.tim) >> 16) % 24) + 60 * (bcd_byte(32'(r.tim) >> 8) % 60)
                 + bcd_byte(32'(r.tim)) % 60;
            res.epoch = 32'd86400 * (res.mjd - 32'd40587) + secs;
        end else begin
            res.epoch = r.epoch;
            res.mjd = r.epoch / 86400 + 32'd40587;
            res.date = calendar_date(res.mjd);
            res.tim = 24'((to_bcd(r.epoch / 3600 % 24) << 16) | (to_bcd(r.epoch / 60 % 60) << 8)
                    | to_bcd(r.epoch % 60));
        end
        res.wday = 3'((res.epoch / 86400 + 4) % 7);
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] rand_date();
        return {8'(to_bcd($urandom_range(99))), 8'(to_bcd($urandom_range(99))),
                8'(to_bcd($urandom_range(12))), 8'(to_bcd($urandom_range(31)))};
    endfunction

    task automatic add(input logic f, input logic [31:0] d, input logic [23:0] t,
                       input logic [31:0] e);
        pending_reqs.push_back('{func: f, date: d, tim: t, epoch: e});
    endtask

    // Driver: bursts with random gaps, hold the transaction until accepted.
    int gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && !in_taken) begin
                // hold
            end else if (gap > 0 || pending_reqs.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
                if (gap > 0) gap--;
            end else begin
                conv_req_t r;
                r = pending_reqs.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser <= r.func;
                i_s_axis_tdata <= {r.epoch, r.tim, r.date};
                if ($urandom_range(7) == 0) gap = $urandom_range(5);
            end
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(15) < 11) || (($urandom_range(99)) < 40);
            end
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(convert('{func: i_s_axis_tuser,
                    date: i_s_axis_tdata[31:0], tim: i_s_axis_tdata[55:32],
                    epoch: i_s_axis_tdata[87:56]}));
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", o_m_axis_tdata[31:0], 0);
                end else begin
                    conv_res_t w;
                    w = expected_results.pop_front();
                    if (o_m_axis_tdata[31:0] !== w.epoch)
                        report("epoch", o_m_axis_tdata[31:0], w.epoch);
                    if (o_m_axis_tdata[63:32] !== w.mjd)
                        report("mjd", o_m_axis_tdata[63:32], w.mjd);
                    if (o_m_axis_tdata[66:64] !== w.wday)
                        report("weekday", 32'(o_m_axis_tdata[66:64]), 32'(w.wday));
                    if (o_m_axis_tdata[98:67] !== w.date)
                        report("date", o_m_axis_tdata[98:67], w.date);
                    if (o_m_axis_tdata[122:99] !== w.tim)
                        report("time", 32'(o_m_axis_tdata[122:99]), 32'(w.tim));
                end
            end
        end
    end

    // Long receiver stall partway through so the pipeline fills and stalls input.
    initial begin
        repeat (400) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (80) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        // Directed: field extremes, non-decimal nibbles, early months, wrap dates.
        add(FN_TO_EPOCH, 32'h19700101, 24'h000000, 32'h0);
        add(FN_TO_EPOCH, 32'h20240229, 24'h235959, 32'hFFFFFFFF);
        add(FN_TO_EPOCH, 32'h00000000, 24'h000000, 32'h0);
        add(FN_TO_EPOCH, 32'hFFFFFFFF, 24'hFFFFFF, 32'h0);
        add(FN_TO_EPOCH, 32'h00000101, 24'h995999, 32'h0);
        add(FN_TO_EPOCH, 32'h19691231, 24'h235960, 32'h0);
        add(FN_TO_EPOCH, 32'h21060207, 24'h062815, 32'h0);
        add(FN_TO_EPOCH, 32'h21060208, 24'h000000, 32'h0);
        add(FN_TO_EPOCH, 32'h20001300, 24'h24F9A0, 32'h0);
        add(FN_TO_EPOCH, 32'h2000021F, 24'h120000, 32'h0);
        add(FN_TO_EPOCH, 32'h99991231, 24'h235959, 32'h0);
        add(FN_TO_EPOCH, 32'h1900FF01, 24'h000000, 32'h0);
        add(FN_TO_DATE, 32'hFFFFFFFF, 24'hFFFFFF, 32'h00000000);
        add(FN_TO_DATE, 32'h0, 24'h0, 32'hFFFFFFFF);
        add(FN_TO_DATE, 32'h0, 24'h0, 32'h7FFFFFFF);
        add(FN_TO_DATE, 32'h0, 24'h0, 32'h80000000);
        add(FN_TO_DATE, 32'h0, 24'h0, 32'd951782399);
        add(FN_TO_DATE, 32'h0, 24'h0, 32'd951868800);
        add(FN_TO_DATE, 32'h0, 24'h0, 32'd86399);
        for (int i = 0; i < 1900; i++) begin
            int k;
            k = $urandom_range(9);
            if (k < 4) begin
                add(FN_TO_EPOCH, rand_date(),
                    {8'(to_bcd($urandom_range(23))), 8'(to_bcd($urandom_range(59))),
                     8'(to_bcd($urandom_range(59)))}, $urandom);
            end else if (k < 5) begin
                add(FN_TO_EPOCH, $urandom, 24'($urandom), $urandom);
            end else begin
                add(FN_TO_DATE, $urandom, 24'($urandom), $urandom);
            end
        end
        while (pending_reqs.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/bcec_pkg.sv
rtl/bcd_calendar_epoch_converter.sv
test/tb.sv
